/* hdl/mono_glyph_outline_top_assert.svh */
// Assertion macros shared by the checker files of mono_glyph_outline.
// No dependencies; include by bare file name.
`ifndef MONO_GLYPH_OUTLINE_TOP_ASSERT_SVH
`define MONO_GLYPH_OUTLINE_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define MGO_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mono_glyph_outline: assertion failed");

// next-cycle implication, off during reset
`define MGO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mono_glyph_outline: assertion failed");

// next-cycle implication, checked through reset as well
`define MGO_ASSERT_NEXT_ANY(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mono_glyph_outline: assertion failed");

`endif

/* hdl/mgo_pkg.sv */
// Types and constants for the mono_glyph_outline block.
// No dependencies.
package mgo_pkg;

    localparam int ROW_BITS = 32;
    localparam int CLS_BITS = 2;
    localparam int CLS_WORD = ROW_BITS * CLS_BITS;

    typedef enum logic [CLS_BITS-1:0] {
        PIX_CLEAR   = 2'd0,
        PIX_OUTLINE = 2'd1,
        PIX_GLYPH   = 2'd2
    } t_pix_class;

    typedef struct packed {
        logic [CLS_WORD-1:0] classes;
        logic                frame_end;
    } t_result;

endpackage

/* hdl/mgo_classify.sv */
// Per-pixel four-neighbour classifier for one row of the glyph.
// Depends on mgo_pkg.
module mgo_classify import mgo_pkg::*; (
    input  logic [ROW_BITS-1:0] i_up,
    input  logic [ROW_BITS-1:0] i_cur,
    input  logic [ROW_BITS-1:0] i_down,
    input  logic [ROW_BITS-1:0] i_mask,
    output logic [CLS_WORD-1:0] o_classes
);

    logic [ROW_BITS-1:0] cur_m;
    logic [ROW_BITS-1:0] edge_bits;

    assign cur_m     = i_cur & i_mask;
    // shifted-in zeros stand for the frame edge
    assign edge_bits = ((cur_m << 1) | (cur_m >> 1) | (i_up & i_mask) | (i_down & i_mask))
                       & i_mask & ~cur_m;

    always_comb begin
        for (int i = 0; i < ROW_BITS; i++) begin
            if (cur_m[i]) begin
                o_classes[i*CLS_BITS +: CLS_BITS] = PIX_GLYPH;
            end else if (edge_bits[i]) begin
                o_classes[i*CLS_BITS +: CLS_BITS] = PIX_OUTLINE;
            end else begin
                o_classes[i*CLS_BITS +: CLS_BITS] = PIX_CLEAR;
            end
        end
    end

endmodule

/* hdl/mono_glyph_outline_top.sv */
// Top level of mono_glyph_outline: row registers, classifier pair, result queue.
// Depends on mgo_pkg and mgo_classify.
//
// Usage:
//   Slave stream: s_axis_tdata carries one image row (bit i = column i), s_axis_tlast
//   marks the final row of a frame. Master stream: m_axis_tdata carries two class
//   bits per column, m_axis_tlast marks the final result row of the frame.
//   Config channel: i_cfg_valid/o_cfg_ready write the row width; write it while idle.
//   A transferred row is registered and classified in the next cycle; the results
//   it releases are written into the result queue and shown from then on.
//   Throughput: one row per cycle while the queue has room, set by the single classify
//   pass between the input register and the four-entry result queue. A frame yields one
//   result per row, as a last row after a held row yields two results; the queue's free
//   space gates s_axis_tready.
//   Reset (synchronous, active low) empties the queue and row state and sets the
//   width to 32. A stalled receiver holds m_axis_tdata/tlast steady; the input keeps
//   being taken until the queue cannot take a further row's results.
module mono_glyph_outline_top import mgo_pkg::*; #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [5:0]          i_cfg_data,     // row_width
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [ROW_BITS-1:0] s_axis_tdata,   // [31:0] row_bits
    input  logic                s_axis_tlast,   // last_row
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [CLS_WORD-1:0] m_axis_tdata,   // [63:0] pixel_classes
    output logic                m_axis_tlast    // frame_end
);

    localparam int         QDEPTH = 4;
    localparam int         QPTR_W = $clog2(QDEPTH);
    localparam int         QCNT_W = $clog2(QDEPTH + 3);
    localparam logic [5:0] W_CAP  = 6'(MAX_WIDTH);

    logic [5:0]          r_width;
    logic                r_in_valid;
    logic [ROW_BITS-1:0] r_in_row;
    logic                r_in_last;
    logic [ROW_BITS-1:0] r_above, n_above;
    logic [ROW_BITS-1:0] r_held, n_held;
    logic                r_held_valid, n_held_valid;

    t_result             r_queue [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;

    logic [5:0]          w_eff;
    logic [ROW_BITS-1:0] mask;
    logic [ROW_BITS-1:0] row_m;
    logic [ROW_BITS-1:0] above_b;
    logic [CLS_WORD-1:0] cls_a, cls_b;
    logic [QCNT_W-1:0]   n_push;
    logic [QCNT_W-1:0]   pending;
    t_result             ent0, ent1;
    logic                s_xfer, m_xfer;

    assign w_eff = (r_width > W_CAP) ? W_CAP : r_width;

    always_comb begin
        for (int i = 0; i < ROW_BITS; i++) begin
            mask[i] = (6'(i) < w_eff);
        end
    end

    assign row_m   = r_in_row & mask;
    assign above_b = r_held_valid ? r_held : '0;

    // held row against the incoming row below it
    mgo_classify u_cls_held (
        .i_up      (r_above),
        .i_cur     (r_held),
        .i_down    (row_m),
        .i_mask    (mask),
        .o_classes (cls_a)
    );

    // incoming row as the frame's bottom row
    mgo_classify u_cls_last (
        .i_up      (above_b),
        .i_cur     (row_m),
        .i_down    ('0),
        .i_mask    (mask),
        .o_classes (cls_b)
    );

    always_comb begin
        n_push       = '0;
        n_above      = r_above;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        ent0         = '{classes: cls_b, frame_end: 1'b1};
        ent1         = '{classes: cls_b, frame_end: 1'b1};
        if (r_in_valid) begin
            n_push = QCNT_W'(r_held_valid) + QCNT_W'(r_in_last);
            if (r_held_valid) begin
                ent0 = '{classes: cls_a, frame_end: 1'b0};
            end
            if (r_in_last) begin
                n_above      = '0;
                n_held       = '0;
                n_held_valid = 1'b0;
            end else begin
                n_above      = above_b;
                n_held       = row_m;
                n_held_valid = 1'b1;
            end
        end
    end

    assign pending       = r_in_valid ? n_push : '0;
    assign s_axis_tready = (r_count + pending) <= QCNT_W'(QDEPTH - 2);
    assign s_xfer        = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = (r_count != '0);
    assign m_xfer        = m_axis_tvalid & m_axis_tready;
    assign m_axis_tdata  = r_queue[r_rd_ptr].classes;
    assign m_axis_tlast  = r_queue[r_rd_ptr].frame_end;
    assign o_cfg_ready   = 1'b1;
    assign n_count       = r_count + n_push - QCNT_W'(m_xfer);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= 6'd32;
            r_in_valid   <= 1'b0;
            r_above      <= '0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_width <= i_cfg_data;
            end
            r_in_valid   <= s_xfer;
            r_above      <= n_above;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_wr_ptr     <= r_wr_ptr + QPTR_W'(n_push);
            r_count      <= n_count;
            if (m_xfer) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_in_row  <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (n_push != '0) begin
            r_queue[r_wr_ptr] <= ent0;
        end
        if (n_push == QCNT_W'(2)) begin
            r_queue[r_wr_ptr + QPTR_W'(1)] <= ent1;
        end
    end

endmodule

/* hdl/mgo_checker.sv */
// Port-level checker for mono_glyph_outline_top, bound to the top level.
// Depends on mono_glyph_outline_top_assert.svh and mono_glyph_outline_top.
`include "mono_glyph_outline_top_assert.svh"

module mgo_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    logic s_xfer;
    logic bad_code;

    assign s_xfer   = s_axis_tvalid & s_axis_tready;
    // class code 3 is never produced
    assign bad_code = ((m_axis_tdata & (m_axis_tdata >> 1) & 64'h5555_5555_5555_5555) != 64'd0);

    `MGO_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `MGO_ASSERT_IMPL(a_no_bad_code, i_clk, i_rst_n, m_axis_tvalid, !bad_code)
    `MGO_ASSERT_IMPL(a_rise_after_in, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(s_xfer, 2))
    `MGO_ASSERT_NEXT_ANY(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind mono_glyph_outline_top mgo_checker u_mgo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* tb/tb_mono_glyph_outline_top.sv */
// Self-checking testbench for mono_glyph_outline_top: directed rows from a table, then random
// glyph frames with random gaps on both streams, all checked against a row-outline predictor.
// Depends on mgo_pkg and the mono_glyph_outline_top RTL.
module tb_mono_glyph_outline_top import mgo_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ROWS   = 450;
    localparam int N_DIR         = 24;

    typedef struct {
        int          set_width;   // -1 keeps the current width
        logic [31:0] bits;
        logic        last;
        logic        typed;       // typed_cls replaces the predicted classes
        logic [63:0] typed_cls;
    } t_row_case;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [5:0]          i_cfg_data    = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [ROW_BITS-1:0] s_axis_tdata  = '0;
    logic                s_axis_tlast  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [CLS_WORD-1:0] m_axis_tdata;
    logic                m_axis_tlast;

    // predictor state
    logic [5:0]  width_q;
    logic [31:0] above_q;
    logic [31:0] held_q;
    logic        held_v;
    t_result     expected_rows[$];

    bit no_gaps = 1'b0;
    int mismatches = 0;
    int rows_checked = 0;
    int rows_sent = 0;
    int frames_sent = 0;
    int width_writes = 0;
    int cycles = 0;

    t_row_case dir_rows [N_DIR];

    mono_glyph_outline_top #(.MAX_WIDTH(32)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 36);
    end

    always @(posedge i_clk) begin : watch_results
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_rows.size() == 0) begin
                $error("unexpected result row: pixel_classes %h frame_end %b",
                       m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                want = expected_rows.pop_front();
                rows_checked++;
                if (m_axis_tdata !== want.classes) begin
                    $error("pixel_classes: expected %h, got %h", want.classes, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== want.frame_end) begin
                    $error("frame_end: expected %b, got %b", want.frame_end, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // widths above 32 behave as 32
    function automatic logic [31:0] used_cols(logic [5:0] w);
        if (w >= 6'd32)
            return '1;
        return (32'd1 << w) - 32'd1;
    endfunction

    function automatic logic [63:0] outline_classes(logic [31:0] up, logic [31:0] cur,
                                                    logic [31:0] down, logic [31:0] m);
        logic [31:0] c;
        logic [31:0] near;
        logic [63:0] cls;
        t_pix_class  k;
        c    = cur & m;
        near = ((c << 1) | (c >> 1) | up | down) & m & ~c;
        cls  = '0;
        for (int i = 0; i < 32; i++) begin
            if (c[i])
                k = PIX_GLYPH;
            else if (near[i])
                k = PIX_OUTLINE;
            else
                k = PIX_CLEAR;
            cls[2*i +: 2] = k;
        end
        return cls;
    endfunction

    function automatic void step_outline(logic [31:0] bits, logic last);
        logic [31:0] m;
        logic [31:0] row;
        t_result     r;
        m   = used_cols(width_q);
        row = bits & m;
        if (held_v) begin
            r.classes   = outline_classes(above_q, held_q, row, m);
            r.frame_end = 1'b0;
            expected_rows.push_back(r);
            above_q = held_q;
        end else begin
            above_q = '0;
        end
        held_q = row;
        held_v = 1'b1;
        if (last) begin
            r.classes   = outline_classes(above_q, held_q, '0, m);
            r.frame_end = 1'b1;
            expected_rows.push_back(r);
            above_q = '0;
            held_q  = '0;
            held_v  = 1'b0;
            frames_sent++;
        end
    endfunction

    function automatic logic [31:0] random_row(int unsigned style);
        int unsigned len;
        int unsigned pos;
        case (style)
            0: return $urandom & $urandom & $urandom;
            1: return $urandom | $urandom;
            2: begin
                len = $urandom_range(0, 31);
                pos = $urandom_range(0, 31);
                return ((32'd1 << len) - 32'd1) << pos;
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic push_row(input logic [31:0] bits, input logic last);
        while (!no_gaps && $urandom_range(0, 99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bits;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        step_outline(bits, last);
        rows_sent++;
    endtask

    // hold off the sender until every expected row is back and the pipe is quiet
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [5:0] w);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        width_q = w;
        width_writes++;
    endtask

    initial begin
        t_result     r;
        int          frame_len;
        int unsigned style;
        int          extremes [7];
        bit          paused_once;

        extremes    = '{0, 1, 2, 31, 32, 33, 63};
        paused_once = 1'b0;
        width_q = 6'd32;
        above_q = '0;
        held_q  = '0;
        held_v  = 1'b0;

        dir_rows = '{
            '{-1, 32'h0000_0000, 1'b1, 1'b1, 64'h0},
            '{-1, 32'hFFFF_FFFF, 1'b1, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA},
            '{-1, 32'h0000_0001, 1'b1, 1'b1, 64'h6},
            '{-1, 32'h8000_0000, 1'b1, 1'b1, 64'h9000_0000_0000_0000},
            '{-1, 32'h0000_0000, 1'b0, 1'b0, 64'h0},
            '{-1, 32'h0000_0018, 1'b0, 1'b0, 64'h0},
            '{-1, 32'h0000_003C, 1'b0, 1'b0, 64'h0},
            '{-1, 32'h0000_0018, 1'b0, 1'b0, 64'h0},
            '{-1, 32'h0000_0000, 1'b1, 1'b0, 64'h0},
            // width zero: nothing is in use
            '{0,  32'hFFFF_FFFF, 1'b1, 1'b1, 64'h0},
            '{-1, 32'h1234_5678, 1'b0, 1'b0, 64'h0},
            '{-1, 32'hFFFF_0000, 1'b1, 1'b0, 64'h0},
            // oversized width clamps to the full row
            '{63, 32'hFFFF_FFFF, 1'b1, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA},
            '{1,  32'h0000_0001, 1'b0, 1'b0, 64'h0},
            '{-1, 32'h0000_0003, 1'b1, 1'b0, 64'h0},
            '{5,  32'h0000_0000, 1'b0, 1'b0, 64'h0},
            '{-1, 32'h0000_0004, 1'b0, 1'b0, 64'h0},
            '{-1, 32'h0000_000E, 1'b0, 1'b0, 64'h0},
            '{-1, 32'h0000_0004, 1'b0, 1'b0, 64'h0},
            '{-1, 32'h0000_0000, 1'b1, 1'b0, 64'h0},
            // width changes while a row is held
            '{12, 32'h0000_0000, 1'b0, 1'b0, 64'h0},
            '{-1, 32'h0000_0FFF, 1'b0, 1'b0, 64'h0},
            '{6,  32'h0000_00F0, 1'b0, 1'b0, 64'h0},
            '{-1, 32'h0000_0000, 1'b1, 1'b0, 64'h0}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            if (dir_rows[i].set_width >= 0)
                write_width(6'(dir_rows[i].set_width));
            push_row(dir_rows[i].bits, dir_rows[i].last);
            if (dir_rows[i].typed) begin
                r = expected_rows.pop_back();
                r.classes = dir_rows[i].typed_cls;
                expected_rows.push_back(r);
            end
        end

        while (rows_sent < N_DIR + RANDOM_ROWS) begin
            if (!paused_once && rows_sent >= N_DIR + 300) begin
                drain_results();
                paused_once = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 2) == 0)
                    write_width(6'(extremes[$urandom_range(0, 6)]));
                else
                    write_width(6'($urandom_range(3, 32)));
            end
            case ($urandom_range(0, 9))
                0:       frame_len = 1;
                1:       frame_len = $urandom_range(12, 24);
                default: frame_len = $urandom_range(2, 8);
            endcase
            style = $urandom_range(0, 3);
            for (int k = 0; k < frame_len; k++) begin
                no_gaps = (rows_sent >= N_DIR + 150) && (rows_sent < N_DIR + 250);
                if (k > 0 && $urandom_range(0, 39) == 0)
                    write_width(6'($urandom_range(0, 63)));
                push_row(random_row(style), k == frame_len - 1);
            end
        end
        no_gaps = 1'b0;

        drain_results();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d rows in %0d frames over %0d width settings; %0d result rows checked.",
                 rows_sent, frames_sent, width_writes, rows_checked);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
